// ===== hdl/sed_pkg.sv =====
package sed_pkg;

    // Default depth of the job queue between the parser and the emitter.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Held digits: at most seven are ever stored before an escape completes.
    localparam int DIG_MAX = 7;
    localparam int DIG_W   = 3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_TAB  = 8'h09;

    localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       string_done;
        logic       bad_codepoint;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_SINGLE,
        JOB_UTF8,
        JOB_FLUSH
    } t_job_kind;

    // One parsed item's worth of output work.
    typedef struct packed {
        t_job_kind                kind;
        logic                     is_end;
        logic                     bad;       // single: out-of-range code point
        logic [7:0]               lit_byte;  // single: the byte; flush: tail byte
        logic                     has_tail;
        logic [7:0]               letter;
        logic [DIG_W-1:0]         dig_cnt;
        logic [DIG_MAX-1:0][7:0]  digits;
        logic [20:0]              cp;
    } t_job;

endpackage

// ===== hdl/sed_front.sv =====
module sed_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sed_pkg::t_in_item i_in_data,
    output logic            o_job_valid,
    output sed_pkg::t_job   o_job,
    input  logic            i_job_ready
);

    typedef enum logic [2:0] {
        M_TEXT,
        M_ESC,
        M_X,
        M_SU,
        M_BU
    } t_mode;

    t_mode                                   r_mode, n_mode;
    logic [7:0]                              r_letter, n_letter;
    logic [sed_pkg::DIG_W-1:0]               r_cnt, n_cnt;
    logic [27:0]                             r_accum, n_accum;
    logic [sed_pkg::DIG_MAX-1:0][7:0]        r_digits;

    logic                                    accept;
    logic [7:0]                              b;
    logic                                    e;
    logic [7:0]                              up;
    logic                                    hex_ok;
    logic [3:0]                              hex_val;
    logic [3:0]                              need;
    logic [3:0]                              new_cnt;
    logic [31:0]                             accum_nx;
    logic [sed_pkg::DIG_MAX-1:0][7:0]        dig_cur;
    logic                                    store_dig;
    logic                                    job_valid;
    sed_pkg::t_job                           job;

    assign accept     = i_in_valid && i_job_ready;
    assign o_in_ready = i_job_ready;
    assign b          = i_in_data.in_byte;
    assign e          = i_in_data.end_of_string;
    assign up         = b & ~sed_pkg::CASE_BIT;

    always_comb begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (b >= sed_pkg::CH_ZERO && b <= sed_pkg::CH_NINE) begin
            hex_ok  = 1'b1;
            hex_val = b[3:0];
        end else if (up >= sed_pkg::CH_UP_A && up <= sed_pkg::CH_UP_F) begin
            hex_ok  = 1'b1;
            hex_val = up[3:0] + 4'd9;
        end
    end

    assign new_cnt  = {1'b0, r_cnt} + 4'd1;
    assign accum_nx = {r_accum, hex_val};

    // held digits with the current byte dropped in at the next free slot
    always_comb begin
        for (int k = 0; k < sed_pkg::DIG_MAX; k++) begin
            dig_cur[k] = (k[sed_pkg::DIG_W-1:0] == r_cnt) ? b : r_digits[k];
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_letter  = r_letter;
        n_cnt     = r_cnt;
        n_accum   = r_accum;
        store_dig = 1'b0;
        job_valid = 1'b0;
        job       = '0;
        job.is_end = e;
        need      = 4'd8;

        unique case (r_mode)
            M_TEXT: begin
                if (b == sed_pkg::CH_BSLASH && !e) begin
                    n_mode = M_ESC;
                end else begin
                    job_valid    = 1'b1;
                    job.kind     = sed_pkg::JOB_SINGLE;
                    job.lit_byte = b;
                end
            end
            M_ESC: begin
                n_mode       = M_TEXT;
                job_valid    = 1'b1;
                job.kind     = sed_pkg::JOB_SINGLE;
                job.lit_byte = b;
                unique case (b)
                    sed_pkg::CH_BSLASH: job.lit_byte = sed_pkg::CH_BSLASH;
                    sed_pkg::CH_ZERO:   job.lit_byte = sed_pkg::BYTE_NUL;
                    sed_pkg::CH_QUOTE:  job.lit_byte = sed_pkg::CH_QUOTE;
                    sed_pkg::CH_APOS:   job.lit_byte = sed_pkg::CH_APOS;
                    sed_pkg::CH_LOW_B:  job.lit_byte = sed_pkg::BYTE_BS;
                    sed_pkg::CH_LOW_N:  job.lit_byte = sed_pkg::BYTE_LF;
                    sed_pkg::CH_LOW_R:  job.lit_byte = sed_pkg::BYTE_CR;
                    sed_pkg::CH_LOW_T:  job.lit_byte = sed_pkg::BYTE_TAB;
                    sed_pkg::CH_LOW_X, sed_pkg::CH_LOW_U, sed_pkg::CH_UP_U: begin
                        if (e) begin
                            job.kind   = sed_pkg::JOB_FLUSH;
                            job.letter = b;
                        end else begin
                            job_valid = 1'b0;
                            n_letter  = b;
                            n_cnt     = '0;
                            n_accum   = '0;
                            n_mode    = (b == sed_pkg::CH_LOW_X) ? M_X :
                                        (b == sed_pkg::CH_LOW_U) ? M_SU : M_BU;
                        end
                    end
                    default: begin
                        // unknown escape: backslash and byte go out as-is
                        job.kind   = sed_pkg::JOB_FLUSH;
                        job.letter = b;
                    end
                endcase
            end
            M_X, M_SU, M_BU: begin
                need = (r_mode == M_X) ? 4'd2 : (r_mode == M_SU) ? 4'd4 : 4'd8;
                if (!hex_ok) begin
                    // bad digit: replay the escape, then treat b as text
                    job_valid  = 1'b1;
                    job.kind   = sed_pkg::JOB_FLUSH;
                    job.letter = r_letter;
                    job.dig_cnt = r_cnt;
                    job.digits = r_digits;
                    n_mode     = M_TEXT;
                    n_letter   = '0;
                    n_cnt      = '0;
                    n_accum    = '0;
                    if (b == sed_pkg::CH_BSLASH && !e) begin
                        n_mode = M_ESC;
                    end else begin
                        job.has_tail = 1'b1;
                        job.lit_byte = b;
                    end
                end else if (new_cnt >= need) begin
                    job_valid = 1'b1;
                    n_mode    = M_TEXT;
                    n_letter  = '0;
                    n_cnt     = '0;
                    n_accum   = '0;
                    if (r_mode == M_X) begin
                        job.kind     = sed_pkg::JOB_SINGLE;
                        job.lit_byte = accum_nx[7:0];
                    end else if (accum_nx > sed_pkg::CP_MAX) begin
                        job.kind     = sed_pkg::JOB_SINGLE;
                        job.bad      = 1'b1;
                        job.lit_byte = '0;
                    end else begin
                        job.kind = sed_pkg::JOB_UTF8;
                        job.cp   = accum_nx[20:0];
                    end
                end else if (e) begin
                    job_valid   = 1'b1;
                    job.kind    = sed_pkg::JOB_FLUSH;
                    job.letter  = r_letter;
                    job.dig_cnt = new_cnt[sed_pkg::DIG_W-1:0];
                    job.digits  = dig_cur;
                end else begin
                    store_dig = 1'b1;
                    n_cnt     = new_cnt[sed_pkg::DIG_W-1:0];
                    n_accum   = accum_nx[27:0];
                end
            end
            default: begin
                n_mode = M_TEXT;
            end
        endcase

        if (e) begin
            n_mode   = M_TEXT;
            n_letter = '0;
            n_cnt    = '0;
            n_accum  = '0;
        end
    end

    assign o_job_valid = accept && job_valid;
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_TEXT;
            r_letter <= '0;
            r_cnt    <= '0;
            r_accum  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_letter <= n_letter;
            r_cnt    <= n_cnt;
            r_accum  <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store_dig) begin
            r_digits[r_cnt] <= b;
        end
    end

endmodule

// ===== hdl/sed_queue.sv =====
module sed_queue #(
    parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sed_pkg::t_job i_push_job,
    output logic          o_ready,
    output logic          o_valid,
    output sed_pkg::t_job o_job,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sed_pkg::t_job      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// ===== hdl/sed_back.sv =====
module sed_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sed_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    output sed_pkg::t_out_item o_out_data,
    input  logic               i_out_ready
);

    logic [3:0]          r_idx;
    logic                r_out_valid;
    sed_pkg::t_out_item  r_out;

    logic                load;
    logic [3:0]          len;
    logic [3:0]          off;
    logic [7:0]          byte_sel;
    logic [7:0]          utf_byte;
    logic                last;
    logic [20:0]         cp;

    assign cp   = i_job.cp;
    assign load = i_job_valid && (!r_out_valid || i_out_ready);
    assign off  = r_idx - 4'd2;

    always_comb begin
        unique case (i_job.kind)
            sed_pkg::JOB_UTF8: begin
                if (cp <= 21'h7F) begin
                    len = 4'd1;
                end else if (cp <= 21'h7FF) begin
                    len = 4'd2;
                end else if (cp <= 21'hFFFF) begin
                    len = 4'd3;
                end else begin
                    len = 4'd4;
                end
            end
            sed_pkg::JOB_FLUSH: begin
                len = 4'd2 + {1'b0, i_job.dig_cnt} + {3'b000, i_job.has_tail};
            end
            default: len = 4'd1;
        endcase
    end

    always_comb begin
        unique case (len)
            4'd1: utf_byte = {1'b0, cp[6:0]};
            4'd2: utf_byte = (r_idx[1:0] == 2'd0) ? {3'b110, cp[10:6]}
                                                  : {2'b10, cp[5:0]};
            4'd3: begin
                unique case (r_idx[1:0])
                    2'd0:    utf_byte = {4'b1110, cp[15:12]};
                    2'd1:    utf_byte = {2'b10, cp[11:6]};
                    default: utf_byte = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (r_idx[1:0])
                    2'd0:    utf_byte = {5'b11110, cp[20:18]};
                    2'd1:    utf_byte = {2'b10, cp[17:12]};
                    2'd2:    utf_byte = {2'b10, cp[11:6]};
                    default: utf_byte = {2'b10, cp[5:0]};
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (i_job.kind)
            sed_pkg::JOB_UTF8: byte_sel = utf_byte;
            sed_pkg::JOB_FLUSH: begin
                if (r_idx == 4'd0) begin
                    byte_sel = sed_pkg::CH_BSLASH;
                end else if (r_idx == 4'd1) begin
                    byte_sel = i_job.letter;
                end else if (off < {1'b0, i_job.dig_cnt}) begin
                    byte_sel = i_job.digits[off[sed_pkg::DIG_W-1:0]];
                end else begin
                    byte_sel = i_job.lit_byte;
                end
            end
            default: byte_sel = i_job.lit_byte;
        endcase
    end

    assign last  = (r_idx == len - 4'd1);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= last ? 4'd0 : r_idx + 4'd1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte      <= byte_sel;
            r_out.last_of_run   <= last;
            r_out.string_done   <= last && i_job.is_end;
            r_out.bad_codepoint <= i_job.bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/string_escape_decoder_unit.sv =====
// Backslash-escape decoder with UTF-8 output.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one byte of the escaped
// string per transfer, with end_of_string set on its last byte. Output channel
// (o_out_valid / i_out_ready / o_out_data): one decoded byte per transfer,
// with last_of_run on the final byte an input caused, string_done on the final
// byte of the string and bad_codepoint on the single result of a \U value
// above U+10FFFF.
//
// An input's first result passes the job queue, then the output register.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver keeps up. An input that yields N results (up to
// 10, for a replayed \U escape) holds the emitter until all N are out; the
// parser keeps accepting until the job queue (QUEUE_DEPTH entries) fills,
// then drops o_in_ready.
//
// When the receiver stalls, the output register holds its byte, the emitter
// waits, and input backs up through the job queue to o_in_ready.
// Reset (synchronous, active low) returns the parser to plain text and
// empties the queue and the output register. No clearing pass is needed.
module string_escape_decoder_unit #(
    parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sed_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sed_pkg::t_out_item o_out_data
);

    // parser -> queue
    logic          push;
    sed_pkg::t_job push_job;
    logic          q_ready;

    // queue -> emitter
    logic          q_valid;
    sed_pkg::t_job q_job;
    logic          pop;

    // Parser: tracks escape state, turns each byte into at most one job.
    sed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (push),
        .o_job       (push_job),
        .i_job_ready (q_ready)
    );

    // Short job queue decoupling parse from emit.
    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_job      (q_job),
        .i_pop      (pop)
    );

    // Emitter: walks a job one output byte per cycle into the output register, unless stalled.
    sed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

// ===== hdl/sed_checker.sv =====
module sed_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input sed_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sed_pkg::t_out_item o_out_data
);

    // offered input holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.string_done |-> o_out_data.last_of_run)
        else $error("string_done without last_of_run");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_codepoint |->
            o_out_data.out_byte == 8'h00 && o_out_data.last_of_run)
        else $error("malformed bad code point result");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (.*);
